/* sv/direct_mapped_writeback_cache_top_assert.svh */
// Assertion macros for the SVA checker file of the cache.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TOP_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DMWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DMWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dmwc_pkg.sv */
`default_nettype none

package dmwc_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 32;
  localparam int COST_W     = 16;
  localparam int TIME_W     = 32;
  localparam int WORD_BYTES = 4;
  localparam int WORD_AW    = 2;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [1:0] REG_MEM_RD_COST   = 2'd0;
  localparam logic [1:0] REG_MEM_WR_COST   = 2'd1;
  localparam logic [1:0] REG_CACHE_RD_COST = 2'd2;
  localparam logic [1:0] REG_CACHE_WR_COST = 2'd3;

  localparam logic [COST_W-1:0] MEM_RD_COST_RST   = 16'd100;
  localparam logic [COST_W-1:0] MEM_WR_COST_RST   = 16'd50;
  localparam logic [COST_W-1:0] CACHE_RD_COST_RST = 16'd1;
  localparam logic [COST_W-1:0] CACHE_WR_COST_RST = 16'd1;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              was_hit;
    logic              range_error;
    logic [TIME_W-1:0] elapsed_time;
  } out_t;

  typedef struct packed {
    logic [COST_W-1:0] memory_read_cost;
    logic [COST_W-1:0] memory_write_cost;
    logic [COST_W-1:0] cache_read_cost;
    logic [COST_W-1:0] cache_write_cost;
  } cost_t;

endpackage

`default_nettype wire

/* sv/dmwc_ram.sv */
`default_nettype none

module dmwc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/dmwc_cfg.sv */
`default_nettype none

module dmwc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dmwc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [dmwc_pkg::CFG_DW-1:0] pwdata,
  output logic      [dmwc_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output dmwc_pkg::cost_t                  cost
);

  dmwc_pkg::cost_t cost_r;
  dmwc_pkg::cost_t cost_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cost_nxt = cost_r;
    if (wr_en) begin
      case (reg_idx)
        dmwc_pkg::REG_MEM_RD_COST:   cost_nxt.memory_read_cost  = pwdata[15:0];
        dmwc_pkg::REG_MEM_WR_COST:   cost_nxt.memory_write_cost = pwdata[15:0];
        dmwc_pkg::REG_CACHE_RD_COST: cost_nxt.cache_read_cost   = pwdata[15:0];
        dmwc_pkg::REG_CACHE_WR_COST: cost_nxt.cache_write_cost  = pwdata[15:0];
        default: cost_nxt = cost_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r.memory_read_cost  <= dmwc_pkg::MEM_RD_COST_RST;
      cost_r.memory_write_cost <= dmwc_pkg::MEM_WR_COST_RST;
      cost_r.cache_read_cost   <= dmwc_pkg::CACHE_RD_COST_RST;
      cost_r.cache_write_cost  <= dmwc_pkg::CACHE_WR_COST_RST;
    end else begin
      cost_r <= cost_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      dmwc_pkg::REG_MEM_RD_COST:   prdata = {16'd0, cost_r.memory_read_cost};
      dmwc_pkg::REG_MEM_WR_COST:   prdata = {16'd0, cost_r.memory_write_cost};
      dmwc_pkg::REG_CACHE_RD_COST: prdata = {16'd0, cost_r.cache_read_cost};
      dmwc_pkg::REG_CACHE_WR_COST: prdata = {16'd0, cost_r.cache_write_cost};
      default:                     prdata = '0;
    endcase
  end

  assign cost = cost_r;

endmodule

`default_nettype wire

/* sv/direct_mapped_writeback_cache_top.sv */
// Direct-mapped, write-back, write-allocate cache with its backing memory.
// Input channel in_valid/in_stall/in_data carries one word read or write per
// transaction; output channel out_valid/out_stall/out_data returns one result
// per transaction, in order. Cost registers are written over the APB port.
// After reset the block sweeps the backing memory and the tag store to zero;
// in_stall stays high during the sweep.
// A hit or an out-of-range access first reads the tag store; a hit then
// accesses the data memory, both on single-port memories, and a new
// transaction is accepted only once the block is back in its idle state.
// A clean miss refills the line from the backing memory, and a dirty miss
// first writes the old line back; both move the block one word per cycle
// through the data and backing memory ports, W = BLOCK_BYTES/4 words.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver keeps stalling, the following result waits in
// the cache and in_stall rises until the output register frees up.
`default_nettype none

module direct_mapped_writeback_cache_top #(
  parameter int CACHE_BYTES  = 256,
  parameter int BLOCK_BYTES  = 64,
  parameter int MEMORY_BYTES = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire dmwc_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dmwc_pkg::out_t                   out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dmwc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [dmwc_pkg::CFG_DW-1:0] pwdata,
  output logic      [dmwc_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);

  localparam int WPB         = BLOCK_BYTES / dmwc_pkg::WORD_BYTES;
  localparam int NUM_LINES   = CACHE_BYTES / BLOCK_BYTES;
  localparam int CACHE_WORDS = CACHE_BYTES / dmwc_pkg::WORD_BYTES;
  localparam int MEM_WORDS   = MEMORY_BYTES / dmwc_pkg::WORD_BYTES;
  localparam int CACHE_AW    = $clog2(CACHE_BYTES);
  localparam int BLK_AW      = $clog2(BLOCK_BYTES);
  localparam int WOB         = BLK_AW - dmwc_pkg::WORD_AW;
  localparam int LINE_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CA_W        = $clog2(CACHE_WORDS);
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int TAG_W       = (dmwc_pkg::ADDR_W > CACHE_AW) ?
                               (dmwc_pkg::ADDR_W - CACHE_AW) : 1;
  localparam int TE_W        = TAG_W + 2;
  localparam int CNT_W       = $clog2(WPB + 1);
  localparam int SWEEP_N     = (MEM_WORDS > NUM_LINES) ? MEM_WORDS : NUM_LINES;
  localparam int SW_W        = $clog2(SWEEP_N);

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TAG   = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;

  dmwc_pkg::cost_t cost;

  logic [2:0]        state_r, state_nxt;
  logic [SW_W-1:0]   sw_r, sw_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       time_r, time_nxt;
  dmwc_pkg::in_t     req_r, req_nxt;
  logic              err_r, err_nxt;
  logic              hit_r, hit_nxt;
  logic              pend_r, pend_nxt;
  logic              fill_ok_r, fill_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  dmwc_pkg::out_t    out_r;

  logic              bk_en, bk_we;
  logic [MEM_AW-1:0] bk_addr;
  logic [31:0]       bk_wdata, bk_rdata;
  logic              cd_en, cd_we;
  logic [CA_W-1:0]   cd_addr;
  logic [31:0]       cd_wdata, cd_rdata;
  logic              tg_en, tg_we;
  logic [LINE_W-1:0] tg_addr;
  logic [TE_W-1:0]   tg_wdata, tg_rdata;

  logic              cap;
  logic              in_acc;
  logic              in_err;
  logic [LINE_W-1:0] in_idx;
  logic [LINE_W-1:0] cur_idx;
  logic [TAG_W-1:0]  cur_tag;
  logic [31:0]       blk_base;
  logic [CA_W-1:0]   acc_addr;
  logic [31:0]       new_w;
  logic [31:0]       old_w;
  logic [31:0]       wb_w;
  logic [31:0]       fill_w;
  logic              wb_ok;
  logic              fill_rd_ok;
  logic              line_hit;
  logic              line_dirty;
  logic [15:0]       acc_cost;
  logic              cnt_last;
  logic              cnt_busy;

  dmwc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cost    (cost)
  );

  dmwc_ram #(.DEPTH(MEM_WORDS), .WIDTH(32)) u_backing (
    .clk   (clk),
    .en    (bk_en),
    .we    (bk_we),
    .addr  (bk_addr),
    .wdata (bk_wdata),
    .rdata (bk_rdata)
  );

  dmwc_ram #(.DEPTH(CACHE_WORDS), .WIDTH(32)) u_data (
    .clk   (clk),
    .en    (cd_en),
    .we    (cd_we),
    .addr  (cd_addr),
    .wdata (cd_wdata),
    .rdata (cd_rdata)
  );

  dmwc_ram #(.DEPTH(NUM_LINES), .WIDTH(TE_W)) u_tags (
    .clk   (clk),
    .en    (tg_en),
    .we    (tg_we),
    .addr  (tg_addr),
    .wdata (tg_wdata),
    .rdata (tg_rdata)
  );

  assign cap      = (state_r == ST_IDLE) && pend_r && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != ST_IDLE) || (pend_r && !cap);
  assign in_acc   = in_valid && !in_stall;

  assign in_err = 32'(in_data.byte_address[15:2]) >= 32'(MEM_WORDS);
  assign in_idx = LINE_W'((32'(in_data.byte_address) >> BLK_AW) & 32'(NUM_LINES - 1));

  assign cur_idx  = LINE_W'((32'(req_r.byte_address) >> BLK_AW) & 32'(NUM_LINES - 1));
  assign cur_tag  = TAG_W'(32'(req_r.byte_address) >> CACHE_AW);
  assign blk_base = 32'(cur_idx) << WOB;
  assign acc_addr = CA_W'(blk_base |
                          (32'(req_r.byte_address[15:2]) & 32'(WPB - 1)));
  assign new_w    = 32'(req_r.byte_address[15:2]) & ~32'(WPB - 1);
  assign old_w    = (32'(tg_rdata[TAG_W-1:0]) << (CACHE_AW - dmwc_pkg::WORD_AW)) |
                    (32'(cur_idx) << WOB);
  assign wb_w       = old_w + 32'(cnt_r) - 32'd1;
  assign fill_w     = new_w + 32'(cnt_r);
  assign wb_ok      = wb_w < 32'(MEM_WORDS);
  assign fill_rd_ok = fill_w < 32'(MEM_WORDS);

  assign line_hit   = tg_rdata[TE_W-1] && (tg_rdata[TAG_W-1:0] == cur_tag);
  assign line_dirty = tg_rdata[TE_W-1] && tg_rdata[TE_W-2];
  assign acc_cost   = req_r.func ? cost.cache_write_cost : cost.cache_read_cost;
  assign cnt_last   = cnt_r == CNT_W'(WPB);
  assign cnt_busy   = 32'(cnt_r) < 32'(WPB);

  always_comb begin
    state_nxt   = state_r;
    sw_nxt      = sw_r;
    cnt_nxt     = cnt_r;
    time_nxt    = time_r;
    req_nxt     = req_r;
    err_nxt     = err_r;
    hit_nxt     = hit_r;
    pend_nxt    = pend_r && !cap;
    fill_ok_nxt = fill_ok_r;
    bk_en       = 1'b0;
    bk_we       = 1'b0;
    bk_addr     = '0;
    bk_wdata    = '0;
    cd_en       = 1'b0;
    cd_we       = 1'b0;
    cd_addr     = acc_addr;
    cd_wdata    = req_r.write_data;
    tg_en       = 1'b0;
    tg_we       = 1'b0;
    tg_addr     = cur_idx;
    tg_wdata    = {1'b1, req_r.func, cur_tag};
    case (state_r)
      ST_SWEEP: begin
        bk_en   = 32'(sw_r) < 32'(MEM_WORDS);
        bk_we   = bk_en;
        bk_addr = sw_r[MEM_AW-1:0];
        tg_en   = 32'(sw_r) < 32'(NUM_LINES);
        tg_we   = tg_en;
        tg_addr = sw_r[LINE_W-1:0];
        tg_wdata = '0;
        sw_nxt  = sw_r + 1'b1;
        if (sw_r == SW_W'(SWEEP_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_data;
          err_nxt   = in_err;
          tg_en     = 1'b1;
          tg_addr   = in_idx;
          state_nxt = ST_TAG;
        end
      end
      ST_TAG: begin
        if (err_r) begin
          hit_nxt   = 1'b0;
          pend_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (line_hit) begin
          hit_nxt   = 1'b1;
          cd_en     = 1'b1;
          cd_we     = req_r.func;
          tg_en     = req_r.func;
          tg_we     = req_r.func;
          time_nxt  = time_r + 32'(acc_cost);
          pend_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          hit_nxt   = 1'b0;
          cnt_nxt   = '0;
          time_nxt  = time_r + 32'(cost.memory_read_cost);
          state_nxt = line_dirty ? ST_WB : ST_FILL;
        end
      end
      ST_WB: begin
        if (cnt_r == '0) begin
          time_nxt = time_r + 32'(cost.memory_write_cost);
        end else begin
          bk_en    = wb_ok;
          bk_we    = wb_ok;
          bk_addr  = wb_w[MEM_AW-1:0];
          bk_wdata = cd_rdata;
        end
        if (cnt_busy) begin
          cd_en   = 1'b1;
          cd_addr = CA_W'(blk_base + 32'(cnt_r));
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_busy) begin
          bk_en       = fill_rd_ok;
          bk_addr     = fill_w[MEM_AW-1:0];
          fill_ok_nxt = fill_rd_ok;
        end
        if (cnt_r != '0) begin
          cd_en    = 1'b1;
          cd_we    = 1'b1;
          cd_addr  = CA_W'(blk_base + 32'(cnt_r) - 32'd1);
          cd_wdata = fill_ok_r ? bk_rdata : 32'd0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cd_en     = 1'b1;
        cd_we     = req_r.func;
        tg_en     = 1'b1;
        tg_we     = 1'b1;
        time_nxt  = time_r + 32'(acc_cost);
        pend_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cap || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      cnt_r       <= '0;
      time_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    err_r     <= err_nxt;
    hit_r     <= hit_nxt;
    fill_ok_r <= fill_ok_nxt;
    if (cap) begin
      out_r.read_data    <= (!req_r.func && !err_r) ? cd_rdata : 32'd0;
      out_r.was_hit      <= hit_r;
      out_r.range_error  <= err_r;
      out_r.elapsed_time <= time_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* sv/dmwc_checker.sv */
`default_nettype none
`include "direct_mapped_writeback_cache_top_assert.svh"

module dmwc_sva_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire dmwc_pkg::out_t out_data,
  input wire logic           pready
);

  `DMWC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `DMWC_ASSERT_IMP(a_err_clean, out_valid && out_data.range_error, (out_data.read_data == 32'd0) && !out_data.was_hit, "range error result carries data or hit")
  `DMWC_ASSERT_IMP(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind direct_mapped_writeback_cache_top dmwc_sva_checker u_dmwc_checker (.*);

`default_nettype wire

/* sim/dmwc_checker.sv */
module dmwc_checker
  import dmwc_pkg::*;
#(
  parameter int CACHE_BYTES  = 256,
  parameter int BLOCK_BYTES  = 64,
  parameter int MEMORY_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                pending,
  output int                errors,
  output int                hits,
  output int                writebacks
);

  localparam int LINES       = CACHE_BYTES / BLOCK_BYTES;
  localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
  localparam int MEM_WORDS   = MEMORY_BYTES / WORD_BYTES;

  logic [COST_W-1:0] mem_rd_cost, mem_wr_cost, cache_rd_cost, cache_wr_cost;
  logic [DATA_W-1:0] cache_data [LINES*BLOCK_WORDS];
  int unsigned       line_tag [LINES];
  bit                line_valid [LINES];
  bit                line_dirty [LINES];
  logic [DATA_W-1:0] memory_words [MEM_WORDS];
  logic [TIME_W-1:0] elapsed;
  out_t              expected_results [$];
  out_t              oldest;

  initial begin
    pending    = 0;
    errors     = 0;
    hits       = 0;
    writebacks = 0;
  end

  function automatic out_t predict_access(input in_t t);
    int unsigned       addr, tag, line, woff, base, blk_word, victim_word;
    logic [DATA_W-1:0] fill [BLOCK_WORDS];
    out_t              r;
    r = '0;
    addr = (int'(t.byte_address) / WORD_BYTES) * WORD_BYTES;
    if (addr + WORD_BYTES > MEMORY_BYTES) begin
      r.range_error  = 1'b1;
      r.elapsed_time = elapsed;
      return r;
    end
    tag  = addr / CACHE_BYTES;
    line = (addr / BLOCK_BYTES) % LINES;
    woff = (addr % BLOCK_BYTES) / WORD_BYTES;
    base = line * BLOCK_WORDS;
    r.was_hit = line_valid[line] && (line_tag[line] == tag);
    if (!r.was_hit) begin
      blk_word = (addr / BLOCK_BYTES) * BLOCK_WORDS;
      for (int k = 0; k < BLOCK_WORDS; k++) fill[k] = memory_words[blk_word + k];
      elapsed += TIME_W'(mem_rd_cost);
      if (line_valid[line] && line_dirty[line]) begin
        victim_word = (line_tag[line] * CACHE_BYTES + line * BLOCK_BYTES) / WORD_BYTES;
        for (int k = 0; k < BLOCK_WORDS; k++)
          memory_words[victim_word + k] = cache_data[base + k];
        elapsed += TIME_W'(mem_wr_cost);
        writebacks++;
      end
      for (int k = 0; k < BLOCK_WORDS; k++) cache_data[base + k] = fill[k];
      line_valid[line] = 1'b1;
      line_tag[line]   = tag;
      line_dirty[line] = 1'b0;
    end else begin
      hits++;
    end
    if (t.func) begin
      cache_data[base + woff] = t.write_data;
      line_dirty[line] = 1'b1;
      elapsed += TIME_W'(cache_wr_cost);
    end else begin
      r.read_data = cache_data[base + woff];
      elapsed += TIME_W'(cache_rd_cost);
    end
    r.elapsed_time = elapsed;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mem_rd_cost   = MEM_RD_COST_RST;
      mem_wr_cost   = MEM_WR_COST_RST;
      cache_rd_cost = CACHE_RD_COST_RST;
      cache_wr_cost = CACHE_WR_COST_RST;
      foreach (cache_data[i]) cache_data[i] = '0;
      foreach (memory_words[i]) memory_words[i] = '0;
      foreach (line_tag[i]) begin
        line_tag[i]   = 0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      elapsed = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MEM_RD_COST:   mem_rd_cost   = pwdata[COST_W-1:0];
          REG_MEM_WR_COST:   mem_wr_cost   = pwdata[COST_W-1:0];
          REG_CACHE_RD_COST: cache_rd_cost = pwdata[COST_W-1:0];
          REG_CACHE_WR_COST: cache_wr_cost = pwdata[COST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction %h arrived with none expected", $time, out_data);
        end else begin
          oldest = expected_results.pop_front();
          if (out_data.read_data !== oldest.read_data) begin
            errors++;
            $display("%0t: read_data expected %h got %h", $time,
                     oldest.read_data, out_data.read_data);
          end
          if (out_data.was_hit !== oldest.was_hit) begin
            errors++;
            $display("%0t: was_hit expected %b got %b", $time,
                     oldest.was_hit, out_data.was_hit);
          end
          if (out_data.range_error !== oldest.range_error) begin
            errors++;
            $display("%0t: range_error expected %b got %b", $time,
                     oldest.range_error, out_data.range_error);
          end
          if (out_data.elapsed_time !== oldest.elapsed_time) begin
            errors++;
            $display("%0t: elapsed_time expected %h got %h", $time,
                     oldest.elapsed_time, out_data.elapsed_time);
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_access(in_data));
    end
    pending = expected_results.size();
  end

endmodule

/* sim/tb_direct_mapped_writeback_cache_top.sv */
module tb_direct_mapped_writeback_cache_top;
  import dmwc_pkg::*;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam int   CYCLE_LIMIT = 1500000;
  localparam int   HIT_ITEMS   = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int pending, errors, hits, writebacks;
  int sent = 0;
  int settings = 1;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  direct_mapped_writeback_cache_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dmwc_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .pending, .errors, .hits, .writebacks
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between stall rates, and on request holds off for a long stretch.
  initial begin
    int rate, run_left;
    rate = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(3))
            0: rate = 0;
            1: rate = 20;
            2: rate = 50;
            default: rate = 85;
          endcase
          run_left = $urandom_range(5, 80);
        end
        run_left--;
        out_stall <= ($urandom_range(99) < rate);
      end
    end
  end

  function automatic in_t make_txn(input logic f, input logic [ADDR_W-1:0] a,
                                   input logic [DATA_W-1:0] d);
    in_t r;
    r.func         = f;
    r.byte_address = a;
    r.write_data   = d;
    return r;
  endfunction

  task automatic send_txn(input in_t t);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    pause(1);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [COST_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DW-COST_W){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_costs(input logic [COST_W-1:0] mrd, mwr, crd, cwr);
    write_reg(REG_MEM_RD_COST, mrd);
    write_reg(REG_MEM_WR_COST, mwr);
    write_reg(REG_CACHE_RD_COST, crd);
    write_reg(REG_CACHE_WR_COST, cwr);
    settings++;
  endtask

  // Most accesses stay in the current block or a small set of tags so that
  // hits, clean refills and dirty evictions all occur; the rest are anywhere.
  task automatic run_random(input int n);
    logic [7:0]        tags [8];
    logic [ADDR_W-1:0] addr;
    int                burst, pick;
    foreach (tags[i]) tags[i] = 8'($urandom_range(255));
    addr  = ADDR_W'($urandom_range(16'hFFFF));
    burst = 0;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        addr[5:0] = 6'($urandom_range(63));
      end else if (pick < 85) begin
        addr[15:8] = tags[$urandom_range(7)];
        addr[7:0]  = 8'($urandom_range(255));
      end else begin
        addr = ADDR_W'($urandom_range(16'hFFFF));
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        pause($urandom_range(0, 12));
      end
      burst--;
      send_txn(make_txn(1'($urandom_range(1)), addr, $urandom));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] blk;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_txn(make_txn(FUNC_READ,  16'h0000, 32'h0));
    send_txn(make_txn(FUNC_WRITE, 16'h0004, 32'hFFFF_FFFF));
    send_txn(make_txn(FUNC_READ,  16'h0007, 32'hFFFF_FFFF));
    send_txn(make_txn(FUNC_WRITE, 16'hFFFF, 32'hA5A5_A5A5));
    send_txn(make_txn(FUNC_READ,  16'hFFFC, 32'h0));
    send_txn(make_txn(FUNC_WRITE, 16'h00C0, 32'h0000_0000));
    send_txn(make_txn(FUNC_READ,  16'hFFFE, 32'h0));
    send_txn(make_txn(FUNC_READ,  16'h00C0, 32'h0));
    send_txn(make_txn(FUNC_WRITE, 16'h0100, 32'h5A5A_5A5A));
    send_txn(make_txn(FUNC_READ,  16'h0004, 32'h0));
    send_txn(make_txn(FUNC_READ,  16'h0100, 32'h0));
    send_txn(make_txn(FUNC_WRITE, 16'h8040, 32'h1234_5678));
    send_txn(make_txn(FUNC_READ,  16'h8040, 32'h0));
    send_txn(make_txn(FUNC_WRITE, 16'h7FBC, 32'h8765_4321));
    send_txn(make_txn(FUNC_READ,  16'h7FBD, 32'h0));
    run_random(200);

    settle();
    set_costs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(200);

    settle();
    set_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(200);

    settle();
    set_costs(COST_W'($urandom_range(16'hFFFF)), COST_W'($urandom_range(16'hFFFF)),
              COST_W'($urandom_range(16'hFFFF)), COST_W'($urandom_range(16'hFFFF)));
    hold_req = 1'b1;
    run_random(250);

    settle();
    set_costs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    run_random(200);

    settle();
    set_costs(COST_W'($urandom_range(16'hFFFF)), COST_W'($urandom_range(16'hFFFF)),
              COST_W'($urandom_range(15)), COST_W'($urandom_range(15)));
    run_random(200);

    // A closing run of accesses within one block at the highest costs, all hits after the first.
    settle();
    quiet = 1'b1;
    set_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    blk = ADDR_W'($urandom_range(16'hFFFF));
    repeat (HIT_ITEMS) begin
      blk[5:0] = 6'($urandom_range(63));
      send_txn(make_txn(1'($urandom_range(1)), blk, $urandom));
    end

    settle();
    $display("Ran %0d transactions over %0d cost settings, ending with back-to-back hits.",
             sent, settings);
    $display("The run included %0d hits and %0d dirty-line writebacks.", hits, writebacks);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/dmwc_pkg.sv
sv/dmwc_ram.sv
sv/dmwc_cfg.sv
sv/direct_mapped_writeback_cache_top.sv
sv/dmwc_checker.sv
sim/dmwc_checker.sv
sim/tb_direct_mapped_writeback_cache_top.sv
